// File: src/cmtd_pkg.sv
// Shared types and constants of the count-min threshold detector.
package cmtd_pkg;

    localparam logic [31:0] SEED_ONE   = 32'd83233;
    localparam logic [31:0] SEED_TWO   = 32'd135990;
    localparam logic [31:0] SEED_THREE = 32'd69850;

    localparam logic [31:0] MUR_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MUR_C2  = 32'h1b873593;
    localparam logic [31:0] MUR_ADD = 32'he6546b64;
    localparam logic [31:0] MUR_F1  = 32'h85ebca6b;
    localparam logic [31:0] MUR_F2  = 32'hc2b2ae35;

    localparam logic [1:0] LAST_ROW = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_LOADK,
        OP_MUL1,
        OP_MUL2,
        OP_MIX,
        OP_TAIL,
        OP_FIN1,
        OP_FIN2
    } hash_op_t;

    typedef struct packed {
        hash_op_t   op;
        logic [1:0] row;
        logic [1:0] blk;
        logic       key_load;
        logic       tally_inc;
        logic       tally_clr;
        logic       flag_init;
        logic       flag_zero;
        logic       rd_en;
        logic       wr_en;
        logic       sweep;
        logic       load_out;
    } cmtd_cmd_t;

endpackage

// File: src/cmtd_datapath.sv
// Datapath: hash unit, three counter rows, tally, threshold and result registers.
module cmtd_datapath #(
    parameter int ROW_SIZE  = 4096,
    parameter int KEY_BYTES = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmtd_pkg::cmtd_cmd_t     cmd,
    input  logic [$clog2(ROW_SIZE)-1:0] sweep_addr,
    input  logic                    flow_key_in_unused_n,
    input  logic [63:0]             flow_key,
    input  logic                    cfg_wr_en,
    input  logic [31:0]             cfg_wr_data,
    output logic                    crossed,
    output logic [31:0]             search_count
);
    import cmtd_pkg::*;

    localparam int IDX_W      = $clog2(ROW_SIZE);
    localparam int FULL       = KEY_BYTES / 4;
    localparam int REST       = KEY_BYTES % 4;
    localparam int TAIL_SHIFT = 32 * FULL;
    localparam logic [31:0] TAIL_MASK = (REST == 0) ? 32'd0 :
                                        (32'hffffffff >> (32 - 8 * REST));
    localparam logic [31:0] KEY_LEN   = 32'(KEY_BYTES);
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(ROW_SIZE - 1);

    logic [63:0] key_reg;
    logic [31:0] h_reg, h_next;
    logic [31:0] k_reg, k_next;
    logic [31:0] thr_reg;
    logic [31:0] tally_reg;
    logic        all_reg;
    logic        eq_reg;
    logic        crossed_reg;
    logic [31:0] count_reg;
    logic [31:0] rd0_reg, rd1_reg, rd2_reg;

    logic [31:0] mem0 [ROW_SIZE];
    logic [31:0] mem1 [ROW_SIZE];
    logic [31:0] mem2 [ROW_SIZE];

    logic [31:0]      seed;
    logic [31:0]      k_rot;
    logic [31:0]      h_mix;
    logic [31:0]      h_len;
    logic [31:0]      h_fin;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] addr;
    logic [31:0]      rd_sel;
    logic [31:0]      cnt;
    logic [31:0]      wr_data;
    logic [31:0]      tail_word;

    always_comb
    begin
        case (cmd.row)
            2'd0:    seed = SEED_ONE;
            2'd1:    seed = SEED_TWO;
            default: seed = SEED_THREE;
        endcase
    end

    assign tail_word = 32'(key_reg >> TAIL_SHIFT) & TAIL_MASK;
    assign k_rot     = {k_reg[16:0], k_reg[31:17]};
    assign h_mix     = {h_reg[18:0] ^ k_reg[18:0], h_reg[31:19] ^ k_reg[31:19]};
    assign h_len     = h_reg ^ KEY_LEN;
    assign h_fin     = h_reg ^ (h_reg >> 16);
    assign slot      = h_fin[IDX_W-1:0] & IDX_MASK;

    // Hash step: one multiply per cycle, result registered.
    always_comb
    begin
        h_next = h_reg;
        k_next = k_reg;
        case (cmd.op)
            OP_INIT:  h_next = seed;
            OP_LOADK:
            begin
                if (32'(cmd.blk) < 32'(FULL))
                    k_next = (cmd.blk == 2'd0) ? key_reg[31:0] : key_reg[63:32];
                else
                    k_next = tail_word;
            end
            OP_MUL1:  k_next = k_reg * MUR_C1;
            OP_MUL2:  k_next = k_rot * MUR_C2;
            OP_MIX:   h_next = (h_mix << 2) + h_mix + MUR_ADD;
            OP_TAIL:  h_next = h_reg ^ k_reg;
            OP_FIN1:  h_next = (h_len ^ (h_len >> 16)) * MUR_F1;
            OP_FIN2:  h_next = (h_reg ^ (h_reg >> 13)) * MUR_F2;
            default:  h_next = h_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        k_reg <= k_next;
        if (cmd.key_load)
            key_reg <= flow_key;
    end

    always_comb
    begin
        case (cmd.row)
            2'd0:    rd_sel = rd0_reg;
            2'd1:    rd_sel = rd1_reg;
            default: rd_sel = rd2_reg;
        endcase
    end

    assign addr    = cmd.sweep ? sweep_addr : slot;
    assign cnt     = rd_sel + 32'd1;
    assign wr_data = cmd.sweep ? 32'd0 : cnt;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en && cmd.row == 2'd0)
            rd0_reg <= mem0[addr];
        if (cmd.wr_en && (cmd.sweep || cmd.row == 2'd0))
            mem0[addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en && cmd.row == 2'd1)
            rd1_reg <= mem1[addr];
        if (cmd.wr_en && (cmd.sweep || cmd.row == 2'd1))
            mem1[addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en && cmd.row == LAST_ROW)
            rd2_reg <= mem2[addr];
        if (cmd.wr_en && (cmd.sweep || cmd.row == LAST_ROW))
            mem2[addr] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= 32'd0;
            tally_reg <= 32'd0;
        end
        else
        begin
            if (cfg_wr_en)
                thr_reg <= cfg_wr_data;
            if (cmd.tally_clr)
                tally_reg <= 32'd0;
            else if (cmd.tally_inc)
                tally_reg <= tally_reg + 32'd1;
        end
    end

    // Fold each row's new count into the threshold flags.
    always_ff @(posedge clk)
    begin
        if (cmd.flag_init)
        begin
            all_reg <= 1'b1;
            eq_reg  <= 1'b0;
        end
        else if (cmd.flag_zero)
        begin
            all_reg <= 1'b0;
            eq_reg  <= 1'b0;
        end
        else if (cmd.wr_en && !cmd.sweep)
        begin
            all_reg <= all_reg & (cnt >= thr_reg);
            eq_reg  <= eq_reg | (cnt == thr_reg);
        end
        if (cmd.load_out)
        begin
            crossed_reg <= all_reg & eq_reg;
            count_reg   <= tally_reg;
        end
    end

    assign crossed      = crossed_reg & flow_key_in_unused_n;
    assign search_count = count_reg;

endmodule

// File: src/cmtd_controller.sv
// Controller: sequences clear sweeps, hash steps and counter read-modify-writes.
module cmtd_controller #(
    parameter int ROW_SIZE  = 4096,
    parameter int KEY_BYTES = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    output logic                        out_valid,
    input  logic                        out_stall,
    output cmtd_pkg::cmtd_cmd_t         cmd,
    output logic [$clog2(ROW_SIZE)-1:0] sweep_addr
);
    import cmtd_pkg::*;

    localparam int IDX_W = $clog2(ROW_SIZE);
    localparam int FULL  = KEY_BYTES / 4;
    localparam int NBLK  = FULL + ((KEY_BYTES % 4) != 0 ? 1 : 0);
    localparam logic [1:0]       LAST_BLK   = 2'(NBLK - 1);
    localparam logic [1:0]       FULL_BLKS  = 2'(FULL);
    localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(ROW_SIZE - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_LOADK,
        S_MUL1,
        S_MUL2,
        S_MIX,
        S_FIN1,
        S_FIN2,
        S_READ,
        S_WRITE,
        S_POST
    } state_t;

    state_t           state_reg, state_next;
    logic [1:0]       row_reg, row_next;
    logic [1:0]       blk_reg, blk_next;
    logic [IDX_W-1:0] sweep_reg, sweep_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        blk_next       = blk_reg;
        sweep_next     = sweep_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.op         = OP_NONE;
        cmd.row        = row_reg;
        cmd.blk        = blk_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep  = 1'b1;
                cmd.wr_en  = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_SLOT)
                begin
                    sweep_next = '0;
                    state_next = pend_reg ? S_POST : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.key_load = 1'b1;
                    if (action)
                    begin
                        cmd.tally_clr = 1'b1;
                        cmd.flag_zero = 1'b1;
                        pend_next     = 1'b1;
                        state_next    = S_CLEAR;
                    end
                    else
                    begin
                        cmd.tally_inc = 1'b1;
                        cmd.flag_init = 1'b1;
                        row_next      = 2'd0;
                        state_next    = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                cmd.op     = OP_INIT;
                blk_next   = 2'd0;
                state_next = S_LOADK;
            end
            S_LOADK:
            begin
                cmd.op     = OP_LOADK;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.op     = OP_MUL1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.op     = OP_MUL2;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                cmd.op = (blk_reg < FULL_BLKS) ? OP_MIX : OP_TAIL;
                if (blk_reg == LAST_BLK)
                    state_next = S_FIN1;
                else
                begin
                    blk_next   = blk_reg + 2'd1;
                    state_next = S_LOADK;
                end
            end
            S_FIN1:
            begin
                cmd.op     = OP_FIN1;
                state_next = S_FIN2;
            end
            S_FIN2:
            begin
                cmd.op     = OP_FIN2;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.wr_en = 1'b1;
                if (row_reg == LAST_ROW)
                    state_next = S_POST;
                else
                begin
                    row_next   = row_reg + 2'd1;
                    state_next = S_INIT;
                end
            end
            S_POST:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    pend_next      = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            row_reg       <= 2'd0;
            blk_reg       <= 2'd0;
            sweep_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            blk_reg       <= blk_next;
            sweep_reg     <= sweep_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign sweep_addr = sweep_reg;

endmodule

// File: src/count_min_threshold_detector_unit.sv
// Top level of the three-row count-min sketch heavy-hitter detector.
//
//  Channel  Handshake             Payload
//  -------  --------------------  ----------------------------
//  in       in_valid / in_stall   action, flow_key
//  out      out_valid / out_stall crossed, search_count
//  cfg      cfg_wr_en             cfg_wr_data (heavy_threshold)
//
// A count request runs, for each of the three rows in turn, the hash steps
// (seed; per key block of NBLK = ceil(KEY_BYTES / 4): load, two multiplies, mix;
// two finalize steps) and a read-modify-write on that row's counter.
// A clear request sweeps all rows, one slot per cycle.
// After reset the same sweep runs with in_stall high.
// A request is taken while an earlier result still waits on out_stall; its own
// result holds in the controller until the output register frees.
module count_min_threshold_detector_unit #(
    parameter int ROW_SIZE  = 4096,
    parameter int KEY_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [63:0] flow_key,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        crossed,
    output logic [31:0] search_count,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);
    import cmtd_pkg::*;

    localparam int IDX_W = $clog2(ROW_SIZE);

    cmtd_cmd_t        cmd;
    logic [IDX_W-1:0] sweep_addr;

    // Advance the request through sweep, hash and counter steps.
    cmtd_controller #(
        .ROW_SIZE  (ROW_SIZE),
        .KEY_BYTES (KEY_BYTES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cmd        (cmd),
        .sweep_addr (sweep_addr)
    );

    // Hold counters, hash state, threshold and the result register.
    cmtd_datapath #(
        .ROW_SIZE  (ROW_SIZE),
        .KEY_BYTES (KEY_BYTES)
    ) u_dp (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .sweep_addr           (sweep_addr),
        .flow_key_in_unused_n (1'b1),
        .flow_key             (flow_key),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .crossed              (crossed),
        .search_count         (search_count)
    );

endmodule

// File: tb/sv/sketch_scoreboard.sv
// Scoreboard class: count-min sketch prediction and result checking.
class sketch_scoreboard;
    typedef struct {
        bit        crossed;
        bit [31:0] count;
    } sketch_result_t;

    localparam int SLOTS    = 4096;
    localparam int KEY_LEN  = 8;

    bit [31:0]      threshold;
    bit [31:0]      row_one[SLOTS];
    bit [31:0]      row_two[SLOTS];
    bit [31:0]      row_three[SLOTS];
    bit [31:0]      tally;
    sketch_result_t pending[$];
    int             mismatches;
    int             checked;

    function new();
        threshold = '0;
        tally = '0;
        mismatches = 0;
        checked = 0;
        foreach (row_one[i])
        begin
            row_one[i] = '0;
            row_two[i] = '0;
            row_three[i] = '0;
        end
    endfunction

    static function bit [31:0] rotl(bit [31:0] x, int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    static function bit [31:0] scramble(bit [31:0] k);
        k = k * cmtd_pkg::MUR_C1;
        k = rotl(k, 15);
        k = k * cmtd_pkg::MUR_C2;
        return k;
    endfunction

    // 32-bit murmur over the low KEY_LEN bytes, little-endian
    static function bit [31:0] murmur_key(bit [63:0] key, bit [31:0] seed);
        bit [31:0] h;
        bit [31:0] k;
        int        full;
        int        rest;
        h = seed;
        full = KEY_LEN / 4;
        rest = KEY_LEN % 4;
        for (int i = 0; i < full; i++)
        begin
            h ^= scramble(key[32*i +: 32]);
            h = rotl(h, 13);
            h = h * 32'd5 + cmtd_pkg::MUR_ADD;
        end
        if (rest != 0)
        begin
            k = '0;
            for (int j = 0; j < rest; j++)
                k[8*j +: 8] = key[8*(full*4 + j) +: 8];
            h ^= scramble(k);
        end
        h ^= 32'(KEY_LEN);
        h ^= h >> 16;
        h = h * cmtd_pkg::MUR_F1;
        h ^= h >> 13;
        h = h * cmtd_pkg::MUR_F2;
        h ^= h >> 16;
        return h;
    endfunction

    function void note_request(bit clear, bit [63:0] key);
        sketch_result_t r;
        bit [31:0]      a;
        bit [31:0]      b;
        bit [31:0]      c;
        if (clear)
        begin
            foreach (row_one[i])
            begin
                row_one[i] = '0;
                row_two[i] = '0;
                row_three[i] = '0;
            end
            tally = '0;
            r.crossed = 1'b0;
            r.count = '0;
        end
        else
        begin
            tally++;
            a = ++row_one[murmur_key(key, cmtd_pkg::SEED_ONE) % SLOTS];
            b = ++row_two[murmur_key(key, cmtd_pkg::SEED_TWO) % SLOTS];
            c = ++row_three[murmur_key(key, cmtd_pkg::SEED_THREE) % SLOTS];
            r.crossed = (a >= threshold && b >= threshold && c >= threshold) &&
                        (a == threshold || b == threshold || c == threshold);
            r.count = tally;
        end
        pending.push_back(r);
    endfunction

    function void check_result(bit crossed, bit [31:0] count);
        sketch_result_t e;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: crossed=%0d search_count=%0d", crossed, count);
            return;
        end
        e = pending.pop_front();
        checked++;
        if (e.crossed != crossed || e.count != count)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at result %0d: crossed exp %0d got %0d, search_count exp %0d got %0d",
                         checked, e.crossed, crossed, e.count, count);
        end
    endfunction
endclass

// File: tb/sv/testbench.sv
// Top-level testbench of the count-min threshold detector.
module testbench;
    import cmtd_pkg::*;

    localparam int  ROW_SIZE  = 4096;
    localparam int  LIMIT     = 3000000;
    localparam bit  ACT_COUNT = 1'b0;
    localparam bit  ACT_CLEAR = 1'b1;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        action = ACT_COUNT;
    logic [63:0] flow_key = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        crossed;
    logic [31:0] search_count;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;

    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    int               cycles = 0;
    bit [63:0]        key_pool[8];
    sketch_scoreboard sb = new();

    always #1 clk = ~clk;

    count_min_threshold_detector_unit #(
        .ROW_SIZE (ROW_SIZE),
        .KEY_BYTES(8)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .flow_key    (flow_key),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .crossed     (crossed),
        .search_count(search_count),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Sample both handshakes with pre-edge values; the scoreboard sees
    // every accepted request and every accepted result in order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(action, flow_key);
            if (out_valid && !out_stall)
                sb.check_result(crossed, search_count);
        end
    end

    // Receiver back-pressure: stall at random per the current idling mode.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Watchdog: a hung block or handshake ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Offer one request, optionally after a random idle gap; hold it until taken.
    task automatic send_request(bit act, bit [63:0] key);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        flow_key <= key;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid, drain every expected result, then let a full clear sweep pass.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (ROW_SIZE + 64) @(posedge clk);
    endtask

    // Write the threshold while idle and track it in the predictor.
    task automatic set_threshold(bit [31:0] value);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.threshold = value;
    endtask

    // Mostly repeat a small pool of keys so counters climb past the threshold;
    // mix in fresh random keys and the occasional clear.
    task automatic random_phase(int n);
        int pick;
        foreach (key_pool[i])
            key_pool[i] = {$urandom, $urandom};
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick == 0)
                send_request(ACT_CLEAR, {$urandom, $urandom});
            else if (pick < 80)
                send_request(ACT_COUNT, key_pool[$urandom_range(7)]);
            else
                send_request(ACT_COUNT, {$urandom, $urandom});
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: key extremes, repeats that cross a threshold of one,
        // then two, a clear, and counting again after the clear.
        set_threshold(32'd1);
        send_request(ACT_COUNT, 64'h0);
        send_request(ACT_COUNT, 64'hffff_ffff_ffff_ffff);
        send_request(ACT_COUNT, 64'h8000_0000_0000_0000);
        send_request(ACT_COUNT, 64'h0000_0000_0000_0001);
        send_request(ACT_COUNT, 64'haaaa_aaaa_5555_5555);
        send_request(ACT_COUNT, 64'h0);
        send_request(ACT_COUNT, 64'h0);
        send_request(ACT_CLEAR, 64'h0);
        send_request(ACT_COUNT, 64'h0);
        set_threshold(32'd2);
        send_request(ACT_COUNT, 64'h1234_5678_9abc_def0);
        send_request(ACT_COUNT, 64'h1234_5678_9abc_def0);
        send_request(ACT_COUNT, 64'h1234_5678_9abc_def0);
        send_request(ACT_CLEAR, 64'hffff_ffff_ffff_ffff);
        send_request(ACT_COUNT, 64'h1234_5678_9abc_def0);
        send_request(ACT_COUNT, 64'h1234_5678_9abc_def0);

        // Sender idles lightly, receiver heavily.
        send_idle_pct = 32;
        recv_stall_pct = 74;
        set_threshold(32'd3);
        random_phase(400);
        set_threshold(32'hffff_ffff);
        random_phase(100);
        set_threshold(32'd0);
        random_phase(100);

        // Roles swapped.
        send_idle_pct = 74;
        recv_stall_pct = 32;
        set_threshold(32'd2);
        random_phase(500);

        // Full rate both ways.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_threshold(32'd5);
        random_phase(500);

        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

// File: files.f
src/cmtd_pkg.sv
src/cmtd_datapath.sv
src/cmtd_controller.sv
src/count_min_threshold_detector_unit.sv
tb/sv/sketch_scoreboard.sv
tb/sv/testbench.sv
